// ===== rtl/grl_pkg.sv =====
// ----------------------------------------------------------------------------
// grl_pkg
// Shared types and constants of the glyph key recency registry.
// ----------------------------------------------------------------------------
package grl_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int COLOR_W  = 32;
    localparam int CP_W     = 21;
    localparam int SIZE_W   = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [CP_W-1:0]   NARROW_LIMIT = CP_W'(32'h80);
    localparam logic [SIZE_W-1:0] NARROW_MIN   = SIZE_W'(4);
    localparam logic [SIZE_W-1:0] WIDE_MIN     = SIZE_W'(8);
    localparam logic [SIZE_W-1:0] HEIGHT_MIN   = SIZE_W'(8);
    localparam logic [SIZE_W-1:0] NARROW_RST   = SIZE_W'(8);
    localparam logic [SIZE_W-1:0] WIDE_RST     = SIZE_W'(16);
    localparam logic [SIZE_W-1:0] HEIGHT_RST   = SIZE_W'(16);

    localparam logic [1:0] CMD_ENSURE = 2'd0;
    localparam logic [1:0] CMD_PROBE  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_DROP   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_PRIMARY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NARROW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd4;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [CP_W-1:0]    cp;
        logic               fb;
    } key_t;

    typedef struct packed {
        logic [1:0] cmd;
        key_t       key;
        logic       render_ok;
        logic       ready;
    } item_t;

    typedef struct packed {
        logic              primary_ready;
        logic              fallback_ready;
        logic [SIZE_W-1:0] narrow_width;
        logic [SIZE_W-1:0] wide_width;
        logic [SIZE_W-1:0] height;
    } cfg_t;

    typedef struct packed {
        logic              ok;
        logic              was_hit;
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic              evicted;
        key_t              ev_key;
    } result_t;

endpackage

// ===== rtl/grl_front.sv =====
// ----------------------------------------------------------------------------
// grl_front
// Accepts commands, resolves face readiness and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module grl_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  grl_pkg::cfg_t               cfg,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  cmd,
    input  logic [grl_pkg::COLOR_W-1:0] color,
    input  logic [grl_pkg::CP_W-1:0]    code_point,
    input  logic                        use_fallback,
    input  logic                        render_ok,
    output logic                        q_valid,
    output grl_pkg::item_t              q_item,
    input  logic                        q_pop
);

    grl_pkg::item_t slot_reg [2];
    grl_pkg::item_t new_item;
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     fill_reg, fill_next;
    logic           push;
    logic           pop;

    assign in_stall = (fill_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (fill_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        new_item.cmd       = cmd;
        new_item.key.color = color;
        new_item.key.cp    = code_point;
        new_item.key.fb    = use_fallback;
        new_item.render_ok = render_ok;
        new_item.ready     = use_fallback ? cfg.fallback_ready : cfg.primary_ready;
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// ===== rtl/grl_back.sv =====
// ----------------------------------------------------------------------------
// grl_back
// Recency-ordered key cells with parallel compare; executes queued commands.
// ----------------------------------------------------------------------------
module grl_back (
    input  logic              clk,
    input  logic              rst_n,
    input  grl_pkg::cfg_t     cfg,
    input  logic              q_valid,
    input  grl_pkg::item_t    q_item,
    output logic              q_pop,
    output logic              res_valid,
    output grl_pkg::result_t  res,
    input  logic              res_ready
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MATCH = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;
    localparam logic [1:0] ST_DROP  = 2'd3;

    localparam int N = grl_pkg::CAPACITY;

    logic [1:0]                 state_reg, state_next;
    grl_pkg::item_t             cur_reg;
    logic [N-1:0]               match_reg;
    logic [grl_pkg::CNT_W-1:0]  count_reg, count_next;
    grl_pkg::key_t              cell_reg [N];

    logic [N-1:0]               live;
    logic [N-1:0]               match_now;
    logic [N-1:0]               fb_live;
    logic [N-1:0]               sel_vec;
    logic [N-1:0]               above;
    logic [N-1:0]               shift_en;
    logic                       wr_en;
    logic [grl_pkg::CNT_W-1:0]  wr_pos;
    logic                       hit;
    logic                       full;
    logic [grl_pkg::SIZE_W-1:0] cell_w;
    logic [grl_pkg::SIZE_W-1:0] cell_h;

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            live[i]      = grl_pkg::CNT_W'(i) < count_reg;
            match_now[i] = live[i] && (cell_reg[i] == cur_reg.key);
            fb_live[i]   = live[i] && cell_reg[i].fb;
        end
    end

    // all bits at or above the lowest set bit
    assign sel_vec = (state_reg == ST_DROP) ? fb_live : match_reg;
    assign above   = sel_vec | (~sel_vec + N'(1));
    assign hit     = |match_reg;
    assign full    = (count_reg == grl_pkg::CNT_W'(N));

    always_comb
    begin
        if (cur_reg.key.cp < grl_pkg::NARROW_LIMIT)
        begin
            cell_w = (cfg.narrow_width < grl_pkg::NARROW_MIN) ? grl_pkg::NARROW_MIN
                                                              : cfg.narrow_width;
        end
        else
        begin
            cell_w = (cfg.wide_width < grl_pkg::WIDE_MIN) ? grl_pkg::WIDE_MIN
                                                          : cfg.wide_width;
        end
        cell_h = (cfg.height < grl_pkg::HEIGHT_MIN) ? grl_pkg::HEIGHT_MIN : cfg.height;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        q_pop      = 1'b0;
        res_valid  = 1'b0;
        res        = '0;
        shift_en   = '0;
        wr_en      = 1'b0;
        wr_pos     = count_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                state_next = (cur_reg.cmd == grl_pkg::CMD_DROP) ? ST_DROP : ST_APPLY;
            end
            ST_APPLY:
            begin
                if (res_ready)
                begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                    case (cur_reg.cmd)
                        grl_pkg::CMD_ENSURE:
                        begin
                            if (cur_reg.ready && hit)
                            begin
                                // move to most-recent end
                                shift_en    = above;
                                wr_en       = 1'b1;
                                wr_pos      = count_reg - grl_pkg::CNT_W'(1);
                                res.ok      = 1'b1;
                                res.was_hit = 1'b1;
                                res.width   = cell_w;
                                res.height  = cell_h;
                            end
                            else if (cur_reg.ready && cur_reg.render_ok)
                            begin
                                wr_en      = 1'b1;
                                res.ok     = 1'b1;
                                res.width  = cell_w;
                                res.height = cell_h;
                                if (full)
                                begin
                                    shift_en    = '1;
                                    wr_pos      = grl_pkg::CNT_W'(N - 1);
                                    res.evicted = 1'b1;
                                    res.ev_key  = cell_reg[0];
                                end
                                else
                                begin
                                    count_next = count_reg + grl_pkg::CNT_W'(1);
                                end
                            end
                        end
                        grl_pkg::CMD_PROBE:
                        begin
                            if (hit)
                            begin
                                res.ok      = 1'b1;
                                res.was_hit = 1'b1;
                                res.width   = cell_w;
                                res.height  = cell_h;
                            end
                        end
                        grl_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DROP:
            begin
                // remove one fallback key per cycle until none remain
                if (|fb_live)
                begin
                    shift_en   = above;
                    count_next = count_reg - grl_pkg::CNT_W'(1);
                end
                else if (res_ready)
                begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_item;
        end
        if (state_reg == ST_MATCH)
        begin
            match_reg <= match_now;
        end
        for (int i = 0; i < N; i++)
        begin
            if (wr_en && wr_pos[grl_pkg::IDX_W-1:0] == grl_pkg::IDX_W'(i))
            begin
                cell_reg[i] <= cur_reg.key;
            end
            else if (shift_en[i] && i < N - 1)
            begin
                cell_reg[i] <= cell_reg[(i < N - 1) ? i + 1 : i];
            end
        end
    end

endmodule

// ===== rtl/glyph_key_lru_registry.sv =====
// ----------------------------------------------------------------------------
// glyph_key_lru_registry
// Bounded recency-ordered set of glyph keys with ensure, probe, clear and drop.
// ----------------------------------------------------------------------------
// Order: each item passes the two-entry input queue, then the pop, match and apply
// states of the back end, then the output register; a drop removes its fallback keys
// one at a time before its result. The back end works on one item at a time; the
// input queue and the output register decouple both sides.
// Reset: key set empty, config at its reset values; key cells need no clearing.
module glyph_key_lru_registry (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [grl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [grl_pkg::SIZE_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          cmd,
    input  logic [grl_pkg::COLOR_W-1:0]         color,
    input  logic [grl_pkg::CP_W-1:0]            code_point,
    input  logic                                use_fallback,
    input  logic                                render_ok,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                ok,
    output logic                                was_hit,
    output logic [grl_pkg::SIZE_W-1:0]          width,
    output logic [grl_pkg::SIZE_W-1:0]          height,
    output logic                                evicted,
    output logic [grl_pkg::COLOR_W-1:0]         evicted_color,
    output logic [grl_pkg::CP_W-1:0]            evicted_code_point,
    output logic                                evicted_fallback
);

    grl_pkg::cfg_t    cfg_reg;
    grl_pkg::item_t   q_item;
    grl_pkg::result_t res;
    grl_pkg::result_t out_reg;
    logic             out_valid_reg;
    logic             q_valid;
    logic             q_pop;
    logic             res_valid;
    logic             res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.primary_ready  <= 1'b0;
            cfg_reg.fallback_ready <= 1'b0;
            cfg_reg.narrow_width   <= grl_pkg::NARROW_RST;
            cfg_reg.wide_width     <= grl_pkg::WIDE_RST;
            cfg_reg.height         <= grl_pkg::HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                grl_pkg::CFG_PRIMARY:  cfg_reg.primary_ready  <= cfg_data[0];
                grl_pkg::CFG_FALLBACK: cfg_reg.fallback_ready <= cfg_data[0];
                grl_pkg::CFG_NARROW:   cfg_reg.narrow_width   <= cfg_data;
                grl_pkg::CFG_WIDE:     cfg_reg.wide_width     <= cfg_data;
                grl_pkg::CFG_HEIGHT:   cfg_reg.height         <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    grl_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .color        (color),
        .code_point   (code_point),
        .use_fallback (use_fallback),
        .render_ok    (render_ok),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    grl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    // output slot is free when empty or being taken this cycle
    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid          = out_valid_reg;
    assign ok                 = out_reg.ok;
    assign was_hit            = out_reg.was_hit;
    assign width              = out_reg.width;
    assign height             = out_reg.height;
    assign evicted            = out_reg.evicted;
    assign evicted_color      = out_reg.ev_key.color;
    assign evicted_code_point = out_reg.ev_key.cp;
    assign evicted_fallback   = out_reg.ev_key.fb;

endmodule

// ===== dv/glyph_key_registry_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_key_registry_checker
// Watches both channels and the register port of the glyph key registry,
// tracks the key set and its recency order, and compares every result
// transaction with the predicted one, field by field.
// ----------------------------------------------------------------------------
module glyph_key_registry_checker
    import grl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [1:0]           cmd,
    input  logic [COLOR_W-1:0]   color,
    input  logic [CP_W-1:0]      code_point,
    input  logic                 use_fallback,
    input  logic                 render_ok,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic                 ok,
    input  logic                 was_hit,
    input  logic [SIZE_W-1:0]    width,
    input  logic [SIZE_W-1:0]    height,
    input  logic                 evicted,
    input  logic [COLOR_W-1:0]   evicted_color,
    input  logic [CP_W-1:0]      evicted_code_point,
    input  logic                 evicted_fallback,
    output int                   fail_count,
    output int                   pending
);

    key_t    lru_keys[$];
    cfg_t    regs;
    result_t expected_results[$];

    assign pending = expected_results.size();

    function automatic logic [SIZE_W-1:0] cell_width(logic [CP_W-1:0] cp);
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] lo;
        w  = (cp < NARROW_LIMIT) ? regs.narrow_width : regs.wide_width;
        lo = (cp < NARROW_LIMIT) ? NARROW_MIN : WIDE_MIN;
        return (w < lo) ? lo : w;
    endfunction

    function automatic logic [SIZE_W-1:0] cell_height();
        return (regs.height < HEIGHT_MIN) ? HEIGHT_MIN : regs.height;
    endfunction

    function automatic result_t apply_command(logic [1:0] op, key_t k, logic rok);
        result_t r;
        int      hit;
        logic    rdy;
        r   = '0;
        hit = -1;
        foreach (lru_keys[i])
            if (hit < 0 && lru_keys[i] == k)
                hit = i;
        case (op)
            CMD_ENSURE:
            begin
                rdy = k.fb ? regs.fallback_ready : regs.primary_ready;
                if (rdy && (hit >= 0 || rok))
                begin
                    if (hit >= 0)
                    begin
                        lru_keys.delete(hit);
                        r.was_hit = 1'b1;
                    end
                    else if (lru_keys.size() >= CAPACITY)
                    begin
                        r.evicted = 1'b1;
                        r.ev_key  = lru_keys.pop_front();
                    end
                    lru_keys = {lru_keys, k};
                    r.ok     = 1'b1;
                    r.width  = cell_width(k.cp);
                    r.height = cell_height();
                end
            end
            CMD_PROBE:
            begin
                if (hit >= 0)
                begin
                    r.ok      = 1'b1;
                    r.was_hit = 1'b1;
                    r.width   = cell_width(k.cp);
                    r.height  = cell_height();
                end
            end
            CMD_CLEAR: lru_keys.delete();
            default:
            begin
                for (int i = lru_keys.size() - 1; i >= 0; i--)
                    if (lru_keys[i].fb)
                        lru_keys.delete(i);
            end
        endcase
        return r;
    endfunction

    task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t e;
        key_t    k;
        if (!rst_n)
        begin
            lru_keys.delete();
            expected_results.delete();
            fail_count           = 0;
            regs.primary_ready   = 1'b0;
            regs.fallback_ready  = 1'b0;
            regs.narrow_width    = NARROW_RST;
            regs.wide_width      = WIDE_RST;
            regs.height          = HEIGHT_RST;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t unexpected result transaction: expected none actual ok=%0b",
                             $time, ok);
                    fail_count++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    compare_field("ok", 64'(e.ok), 64'(ok));
                    compare_field("was_hit", 64'(e.was_hit), 64'(was_hit));
                    compare_field("width", 64'(e.width), 64'(width));
                    compare_field("height", 64'(e.height), 64'(height));
                    compare_field("evicted", 64'(e.evicted), 64'(evicted));
                    compare_field("evicted_color", 64'(e.ev_key.color),
                                  64'(evicted_color));
                    compare_field("evicted_code_point", 64'(e.ev_key.cp),
                                  64'(evicted_code_point));
                    compare_field("evicted_fallback", 64'(e.ev_key.fb),
                                  64'(evicted_fallback));
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PRIMARY:  regs.primary_ready  = cfg_data[0];
                    CFG_FALLBACK: regs.fallback_ready = cfg_data[0];
                    CFG_NARROW:   regs.narrow_width   = cfg_data;
                    CFG_WIDE:     regs.wide_width     = cfg_data;
                    CFG_HEIGHT:   regs.height         = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                k.color = color;
                k.cp    = code_point;
                k.fb    = use_fallback;
                expected_results = {expected_results, apply_command(cmd, k, render_ok)};
            end
        end
    end

endmodule

// ===== dv/tb_glyph_key_lru_registry.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_glyph_key_lru_registry
// Drives directed and random command streams into the glyph key registry
// under random back-pressure and register settings; a checker beside the
// block predicts each result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_glyph_key_lru_registry;
    import grl_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 200;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SIZE_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [1:0]           cmd;
    logic [COLOR_W-1:0]   color;
    logic [CP_W-1:0]      code_point;
    logic                 use_fallback;
    logic                 render_ok;
    logic                 out_valid;
    logic                 out_stall;
    logic                 ok;
    logic                 was_hit;
    logic [SIZE_W-1:0]    width;
    logic [SIZE_W-1:0]    height;
    logic                 evicted;
    logic [COLOR_W-1:0]   evicted_color;
    logic [CP_W-1:0]      evicted_code_point;
    logic                 evicted_fallback;
    int                   fail_count;
    int                   pending;
    int                   idle_cycles;
    bit                   quiet_tail;
    key_t                 key_pool[$];

    glyph_key_lru_registry u_top (.*);

    glyph_key_registry_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver back-pressure, in short bursts
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 3) - 1) @(negedge clk);
                @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
        @(negedge clk);
        in_valid  = 1'b0;
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // wait until every expected result is back, then let a drop settle
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (CAPACITY + 10) @(negedge clk);
    endtask

    // valid stays up after the transaction; the next call replaces it, a wait or write drops it
    task automatic send(logic [1:0] op, key_t k, logic rok);
        @(negedge clk);
        if (!quiet_tail && $urandom_range(0, 6) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid     = 1'b1;
        cmd          = op;
        color        = k.color;
        code_point   = k.cp;
        use_fallback = k.fb;
        render_ok    = rok;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    function automatic key_t random_key();
        key_t k;
        k.color = $urandom();
        case ($urandom_range(0, 2))
            0: k.cp = CP_W'($urandom_range(0, 8'h7F));
            1: k.cp = CP_W'($urandom_range(8'h80, 8'hFF));
            default: k.cp = CP_W'($urandom_range(0, 21'h10FFFF));
        endcase
        k.fb = 1'($urandom_range(0, 1));
        return k;
    endfunction

    // mostly reuse a small pool so hits, moves and evictions happen
    function automatic key_t pick_key();
        if ($urandom_range(0, 3) != 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        return random_key();
    endfunction

    function automatic logic [1:0] pick_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return CMD_ENSURE;
        if (r < 92) return CMD_PROBE;
        if (r < 96) return CMD_DROP;
        return CMD_CLEAR;
    endfunction

    initial
    begin
        key_t k;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_PRIMARY;
        cfg_data     = '0;
        in_valid     = 1'b0;
        cmd          = CMD_ENSURE;
        color        = '0;
        code_point   = '0;
        use_fallback = 1'b0;
        render_ok    = 1'b0;
        quiet_tail   = 1'b0;
        idle_cycles  = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // faces not ready yet: ensure fails, probe misses
        k = '{color: 32'hFFFF_FFFF, cp: 21'h1F_FFFF, fb: 1'b1};
        send(CMD_ENSURE, k, 1'b1);
        send(CMD_PROBE, k, 1'b0);
        wait_idle();
        write_reg(CFG_PRIMARY, 8'h01);
        write_reg(CFG_FALLBACK, 8'h01);
        write_reg(CFG_NARROW, 8'h00);
        write_reg(CFG_WIDE, 8'h03);
        write_reg(CFG_HEIGHT, 8'h07);
        write_reg(3'd7, 8'hFF);
        send(CMD_ENSURE, k, 1'b1);
        send(CMD_ENSURE, '{color: 32'h0, cp: 21'h7F, fb: 1'b0}, 1'b0);
        send(CMD_ENSURE, '{color: 32'h0, cp: 21'h7F, fb: 1'b0}, 1'b1);
        send(CMD_ENSURE, '{color: 32'h0, cp: 21'h80, fb: 1'b0}, 1'b1);
        send(CMD_ENSURE, k, 1'b0);
        send(CMD_PROBE, '{color: 32'h0, cp: 21'h80, fb: 1'b0}, 1'b0);
        send(CMD_PROBE, '{color: 32'h1, cp: 21'h80, fb: 1'b0}, 1'b0);
        send(CMD_DROP, '0, 1'b0);
        send(CMD_PROBE, k, 1'b1);
        wait_idle();
        write_reg(CFG_FALLBACK, 8'h00);
        write_reg(CFG_NARROW, 8'hFF);
        write_reg(CFG_WIDE, 8'hFF);
        write_reg(CFG_HEIGHT, 8'hFF);
        // dropped key with unready face: ensure fails
        send(CMD_ENSURE, k, 1'b1);
        wait_idle();
        write_reg(CFG_FALLBACK, 8'h01);
        send(CMD_ENSURE, k, 1'b1);
        send(CMD_ENSURE, k, 1'b1);
        send(CMD_PROBE, k, 1'b0);
        // fill past capacity to force evictions
        for (int i = 0; i < CAPACITY + 4; i++)
            send(CMD_ENSURE, random_key(), 1'b1);
        send(CMD_CLEAR, '0, 1'b0);
        send(CMD_PROBE, k, 1'b0);
        wait_idle();

        for (int phase = 0; phase < 5; phase++)
        begin
            write_reg(CFG_PRIMARY, SIZE_W'($urandom_range(0, 3) != 0));
            write_reg(CFG_FALLBACK, SIZE_W'($urandom_range(0, 3) != 0));
            write_reg(CFG_NARROW, SIZE_W'((phase == 0) ? 4 : $urandom_range(0, 255)));
            write_reg(CFG_WIDE, SIZE_W'((phase == 0) ? 8 : $urandom_range(0, 255)));
            write_reg(CFG_HEIGHT, SIZE_W'((phase == 0) ? 8 : $urandom_range(0, 255)));
            key_pool.delete();
            repeat ($urandom_range(20, 100)) key_pool = {key_pool, random_key()};
            if (phase == 4)
                quiet_tail = 1'b1;
            for (int i = 0; i < 240; i++)
            begin
                k = pick_key();
                send(pick_cmd(), k, $urandom_range(0, 4) != 0);
            end
            wait_idle();
        end

        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
